// File: hdl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 16;
  localparam int unsigned TempW     = 15;
  localparam int unsigned HumW      = 14;
  localparam int unsigned OutDataW  = 32;

  localparam logic [ByteW-1:0] CrcPoly = 8'h31;
  localparam logic [ByteW-1:0] CrcInit = 8'hFF;

  typedef logic [ByteW-1:0]        byte_t;
  typedef logic [WordW-1:0]        word_t;
  typedef logic signed [TempW-1:0] temp_centi_t;
  typedef logic [HumW-1:0]         hum_centi_t;

  // position of a byte inside the six-byte frame
  typedef enum logic [2:0] {
    POS_T_MSB = 3'd0,
    POS_T_LSB = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_MSB = 3'd3,
    POS_H_LSB = 3'd4,
    POS_H_CRC = 3'd5
  } pos_e;

  // msb-first crc-8, no reflection, no final xor
  function automatic byte_t crc8_byte(input byte_t crc, input byte_t data);
    byte_t c;
    c = crc ^ data;
    for (int i = 0; i < ByteW; i++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/htfd_convert.sv
// ----------------------------------------------------------------------------
// htfd_convert
// Raw sensor words to hundredths of a degree and of a percent, rounded.
// ----------------------------------------------------------------------------
module htfd_convert (
  input  htfd_pkg::word_t       temp_word_i,
  input  htfd_pkg::word_t       hum_word_i,
  output htfd_pkg::temp_centi_t temp_centi_o,
  output htfd_pkg::hum_centi_t  hum_centi_o
);
  import htfd_pkg::*;

  localparam int unsigned TempScale  = 17500;
  localparam int unsigned HumScale   = 10000;
  localparam int unsigned TempOffset = 4500;
  localparam int unsigned RoundBias  = 32767;
  localparam int unsigned WordMax    = 65535;

  // x / 65535 for x below 2^31: x = q0*65535 + (q0 + low), so one compare fixes it
  function automatic logic [14:0] div_word_max(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] s;
    q0 = x[30:16];
    s  = {2'b00, q0} + {1'b0, x[15:0]};
    return q0 + 15'(s >= 17'(WordMax));
  endfunction

  logic [30:0] temp_prod;
  logic [29:0] hum_prod;
  logic [14:0] temp_q;
  logic [14:0] hum_q;

  always_comb begin
    temp_prod    = 31'(TempScale) * {15'd0, temp_word_i};
    hum_prod     = 30'(HumScale) * {14'd0, hum_word_i};
    temp_q       = div_word_max(temp_prod + 31'(RoundBias));
    hum_q        = div_word_max({1'b0, hum_prod + 30'(RoundBias)});
    temp_centi_o = signed'(temp_q - 15'(TempOffset));
    hum_centi_o  = hum_q[HumW-1:0];
  end

endmodule

// File: hdl/humidity_temperature_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder_top
// Checks the two CRC-8 words of a six-byte sensor frame and holds the
// converted temperature and humidity of the last words that passed.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata                               | tuser
//  ----------+-----------+-------------------------------------+-------------
//  s_axis    | in        | [7:0] data_byte                     | frame_start
//  m_axis    | out       | [14:0] temp, [28:15] hum, [29] t_ok,| -
//            |           | [30] h_ok, [31] zero                |
//
// one byte is taken per cycle while ready; a result appears in the cycle
// after the sixth byte of a frame and sits in the output register until taken.
// a new byte is taken while that result waits unless the register is full
// and the sink stalls. the crc update feeds the crc register; the scaling
// multiply sits between the frame state registers and the output register.
// reset clears the position, held values and flags; crc restarts at 0xff.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  htfd_pkg::byte_t                 s_axis_tdata_i,  // [7:0] data_byte
  input  logic                            s_axis_tuser_i,  // [0] frame_start
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [14:0] temperature_centi, [28:15] humidity_centi, [29] temperature_ok,
  // [30] humidity_ok, [31] zero
  output logic [htfd_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import htfd_pkg::*;

  pos_e        pos_q, pos_d, pos_sel;
  byte_t       crc_q, crc_d;
  word_t       word_q, word_d;
  logic        temp_match_q, temp_match_d;
  word_t       pend_temp_q, pend_temp_d;
  temp_centi_t held_temp_q, held_temp_d;
  hum_centi_t  held_hum_q, held_hum_d;
  logic        out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic        in_fire;
  logic        hum_match;
  temp_centi_t temp_conv;
  hum_centi_t  hum_conv;

  htfd_convert u_convert (
    .temp_word_i  (pend_temp_q),
    .hum_word_i   (word_q),
    .temp_centi_o (temp_conv),
    .hum_centi_o  (hum_conv)
  );

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign pos_sel         = s_axis_tuser_i ? POS_T_MSB : pos_q;
  assign hum_match       = (crc_q == s_axis_tdata_i);

  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    word_d       = word_q;
    temp_match_d = temp_match_q;
    pend_temp_d  = pend_temp_q;
    held_temp_d  = held_temp_q;
    held_hum_d   = held_hum_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_data_d   = out_data_q;

    if (in_fire) begin
      unique case (pos_sel)
        POS_T_LSB, POS_H_LSB: begin
          crc_d  = crc8_byte(crc_q, s_axis_tdata_i);
          word_d = {word_q[ByteW-1:0], s_axis_tdata_i};
          pos_d  = (pos_sel == POS_T_LSB) ? POS_T_CRC : POS_H_CRC;
        end
        POS_H_MSB: begin
          crc_d  = crc8_byte(CrcInit, s_axis_tdata_i);
          word_d = {{(WordW-ByteW){1'b0}}, s_axis_tdata_i};
          pos_d  = POS_H_LSB;
        end
        POS_T_CRC: begin
          temp_match_d = (crc_q == s_axis_tdata_i);
          pend_temp_d  = word_q;
          crc_d        = CrcInit;
          pos_d        = POS_H_MSB;
        end
        POS_H_CRC: begin
          if (temp_match_q) begin
            held_temp_d = temp_conv;
          end
          if (hum_match) begin
            held_hum_d = hum_conv;
          end
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, hum_match, temp_match_q, held_hum_d, held_temp_d};
          crc_d       = CrcInit;
          pos_d       = POS_T_MSB;
        end
        // first byte of a frame, and unreachable positions treated alike
        default: begin
          crc_d  = crc8_byte(CrcInit, s_axis_tdata_i);
          word_d = {{(WordW-ByteW){1'b0}}, s_axis_tdata_i};
          pos_d  = POS_T_LSB;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= POS_T_MSB;
      crc_q        <= CrcInit;
      word_q       <= '0;
      temp_match_q <= 1'b0;
      pend_temp_q  <= '0;
      held_temp_q  <= '0;
      held_hum_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      crc_q        <= crc_d;
      word_q       <= word_d;
      temp_match_q <= temp_match_d;
      pend_temp_q  <= pend_temp_d;
      held_temp_q  <= held_temp_d;
      held_hum_q   <= held_hum_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
